[rtl/core/pcl_pkg.sv]
// Shared constants, codes and the cell command type of the positional circular list engine.
package pcl_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W    = 5;
    localparam int POS_W      = 8;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REVERSE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DUMP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    // cell commands: ROT pulls from the right below j and loads the bus at j,
    // INS pulls from the left above j and loads the bus at j,
    // DEL pulls from the right at and above j
    localparam logic [1:0] CMD_HOLD = 2'd0;
    localparam logic [1:0] CMD_ROT  = 2'd1;
    localparam logic [1:0] CMD_INS  = 2'd2;
    localparam logic [1:0] CMD_DEL  = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic [IDX_W-1:0]      j;
        logic [DATA_WIDTH-1:0] bus;
    } t_cmd;

endpackage

[rtl/core/positional_circular_list_engine.sv]
// Top level of the positional circular list engine: request sequencer and cell chain.
//
// Requests enter on the s_axis channel, results leave on the m_axis channel.
// Request tdata: req_type, position, value_in. Result tdata: status,
// value_out, element_count; tlast marks the final result of a request.
// Values sit in order in a row of 16 cells, head in cell 0.
// Insert and remove do their work in the exec state, which loads the result
// into the output register. Reverse takes count-1 rotate steps and then loads
// its result. Dump rotates the row once per result, one result per cycle
// while the receiver takes them, count results in all (one result with
// status empty on an empty store). A new request is taken once the previous
// one has issued its last result, even while that result still waits in the
// output register.
// Reset clears the state, the count, the step counter and the output valid;
// the cells hold no reset value. When the receiver stalls, the output register
// holds its result and the sequencer waits; reverse steps go on until the final result is due.
module positional_circular_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // req_type[1:0], position[9:2], value_in[41:10]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // status[1:0], value_out[33:2], element_count[38:34]
    output logic        o_m_axis_tlast
);

    localparam int CAP = pcl_pkg::CAPACITY;
    localparam int DW  = pcl_pkg::DATA_WIDTH;
    localparam int IW  = pcl_pkg::IDX_W;
    localparam int CW  = pcl_pkg::COUNT_W;
    localparam int PW  = pcl_pkg::POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_REV  = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [pcl_pkg::REQ_W-1:0]    r_req, n_req;
    logic [PW-1:0]                r_pos, n_pos;
    logic [DW-1:0]                r_vin, n_vin;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [CW-1:0]                r_k, n_k;

    logic                         r_out_valid, n_out_valid;
    logic [pcl_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [DW-1:0]                r_out_value, n_out_value;
    logic [CW-1:0]                r_out_count, n_out_count;
    logic                         r_out_last, n_out_last;

    pcl_pkg::t_cmd                w_cmd;
    logic [DW-1:0]                w_val [CAP];
    logic                         w_out_free;
    logic [PW:0]                  w_pos_x;
    logic [PW:0]                  w_cnt_x;
    logic [CW-1:0]                w_pos_m1;
    logic [CW-1:0]                w_cnt_m1;
    logic [CW-1:0]                w_rev_j;

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_pos_x    = {1'b0, r_pos};
    assign w_cnt_x    = (PW + 1)'(r_cnt);
    assign w_pos_m1   = CW'(w_pos_x - 1'b1);
    assign w_cnt_m1   = r_cnt - 1'b1;
    assign w_rev_j    = w_cnt_m1 - r_k;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_pos        = r_pos;
        n_vin        = r_vin;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        w_cmd.kind   = pcl_pkg::CMD_HOLD;
        w_cmd.j      = '0;
        w_cmd.bus    = w_val[0];
        o_s_axis_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_req   = i_s_axis_tdata[1:0];
                    n_pos   = i_s_axis_tdata[9:2];
                    n_vin   = i_s_axis_tdata[41:10];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = pcl_pkg::ST_OK;
                    n_out_value  = '0;
                    n_out_count  = r_cnt;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                    unique case (r_req)
                        pcl_pkg::REQ_INSERT: begin
                            if (r_pos == '0 || w_pos_x > w_cnt_x + 1'b1) begin
                                n_out_status = pcl_pkg::ST_BAD_POS;
                            end else if (r_cnt == CW'(CAP)) begin
                                n_out_status = pcl_pkg::ST_FULL;
                            end else begin
                                w_cmd.kind  = pcl_pkg::CMD_INS;
                                w_cmd.j     = w_pos_m1[IW-1:0];
                                w_cmd.bus   = r_vin;
                                n_cnt       = r_cnt + 1'b1;
                                n_out_count = r_cnt + 1'b1;
                            end
                        end
                        pcl_pkg::REQ_REMOVE: begin
                            if (r_pos == '0 || w_pos_x > w_cnt_x) begin
                                n_out_status = pcl_pkg::ST_BAD_POS;
                            end else begin
                                w_cmd.kind  = pcl_pkg::CMD_DEL;
                                w_cmd.j     = w_pos_m1[IW-1:0];
                                n_out_value = w_val[w_pos_m1[IW-1:0]];
                                n_cnt       = w_cnt_m1;
                                n_out_count = w_cnt_m1;
                            end
                        end
                        pcl_pkg::REQ_REVERSE: begin
                            if (r_cnt > CW'(1)) begin
                                n_out_valid = r_out_valid && !i_m_axis_tready;
                                n_k         = '0;
                                n_state     = S_REV;
                            end
                        end
                        pcl_pkg::REQ_DUMP: begin
                            if (r_cnt == '0) begin
                                n_out_status = pcl_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !i_m_axis_tready;
                                n_k         = '0;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_REV: begin
                // pop the head and drop it in behind the already reversed part
                if (r_k < w_cnt_m1) begin
                    w_cmd.kind = pcl_pkg::CMD_ROT;
                    w_cmd.j    = w_rev_j[IW-1:0];
                    n_k        = r_k + 1'b1;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = pcl_pkg::ST_OK;
                    n_out_value  = '0;
                    n_out_count  = r_cnt;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_cmd.kind   = pcl_pkg::CMD_ROT;
                    w_cmd.j      = w_cnt_m1[IW-1:0];
                    n_out_valid  = 1'b1;
                    n_out_status = pcl_pkg::ST_OK;
                    n_out_value  = w_val[0];
                    n_out_count  = r_cnt;
                    n_out_last   = (r_k == w_cnt_m1);
                    n_k          = r_k + 1'b1;
                    if (r_k == w_cnt_m1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_pos        <= n_pos;
        r_vin        <= n_vin;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [DW-1:0] w_prev;
        logic [DW-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_val[g-1];
        end
        if (g == CAP - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_val[g+1];
        end
        pcl_cell u_cell (
            .i_clk  (i_clk),
            .i_idx  (IW'(g)),
            .i_cmd  (w_cmd),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_val  (w_val[g])
        );
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_count, r_out_value, r_out_status};
    assign o_m_axis_tlast  = r_out_last;

endmodule

[rtl/core/pcl_cell.sv]
// One storage cell of the list chain: holds one value, shifts it to or from its neighbors.
module pcl_cell (
    input  logic                           i_clk,
    input  logic [pcl_pkg::IDX_W-1:0]      i_idx,
    input  pcl_pkg::t_cmd                  i_cmd,
    input  logic [pcl_pkg::DATA_WIDTH-1:0] i_prev,
    input  logic [pcl_pkg::DATA_WIDTH-1:0] i_next,
    output logic [pcl_pkg::DATA_WIDTH-1:0] o_val
);

    logic [pcl_pkg::DATA_WIDTH-1:0] r_val;
    logic [pcl_pkg::DATA_WIDTH-1:0] n_val;

    always_comb begin
        n_val = r_val;
        unique case (i_cmd.kind)
            pcl_pkg::CMD_ROT: begin
                if (i_idx < i_cmd.j) begin
                    n_val = i_next;
                end else if (i_idx == i_cmd.j) begin
                    n_val = i_cmd.bus;
                end
            end
            pcl_pkg::CMD_INS: begin
                if (i_idx > i_cmd.j) begin
                    n_val = i_prev;
                end else if (i_idx == i_cmd.j) begin
                    n_val = i_cmd.bus;
                end
            end
            pcl_pkg::CMD_DEL: begin
                if (i_idx >= i_cmd.j) begin
                    n_val = i_next;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule
